@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl files of the label flood unit
// every macro samples on clk_i and is switched off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the cycle after
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lf6n_pkg.sv @@
// shared types, widths and helpers of the 6-neighbor label flood unit
// no dependencies; used by lf6n_div and label_flood_6_neighbor_unit
`timescale 1ns / 1ps
`default_nettype none

package lf6n_pkg;

  localparam int unsigned POS_W       = 21;
  localparam int unsigned STORE_DEPTH = 1 << POS_W;
  localparam int unsigned WLABEL_W    = 32;
  localparam int unsigned CNT_W       = 22;
  localparam int unsigned DIM_W       = 8;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 80;

  localparam int unsigned DEFAULT_MAX_SIDE   = 128;
  localparam int unsigned DEFAULT_LABEL_BITS = 32;

  // quotient bits produced per cycle by each coordinate divider
  localparam int unsigned DIV_STEP = 3;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(128);

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = CFG_IDX_W'(2);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_FLOOD = 2'd2
  } func_e;

  // extent as used: zero counts as one, large values clamp to the side limit
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input int unsigned max_side);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (32'(v) > max_side) begin
      return DIM_W'(max_side);
    end else begin
      return v;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/lf6n_div.sv @@
// multi-cycle restoring divider, STEP quotient bits per cycle
// depends on lf6n_pkg for the default widths and step size
`timescale 1ns / 1ps
`default_nettype none

module lf6n_div #(
  parameter int unsigned DIVIDEND_W = lf6n_pkg::POS_W,
  parameter int unsigned DIVISOR_W  = lf6n_pkg::DIM_W,
  parameter int unsigned STEP       = lf6n_pkg::DIV_STEP
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [DIVIDEND_W-1:0]      quotient_o,
  output logic [DIVISOR_W-1:0]       remainder_o
);

  localparam int unsigned Steps = (DIVIDEND_W + STEP - 1) / STEP;
  localparam int unsigned PadW  = Steps * STEP;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CntW-1:0]      cnt_q;
  logic [PadW-1:0]      num_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DIVISOR_W-1:0] den_q;

  logic [PadW-1:0]      num_d;
  logic [DIVISOR_W-1:0] rem_d;
  logic [DIVISOR_W:0]   trial;

  // dividend bits leave at the top while quotient bits enter at the bottom
  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    trial = '0;
    for (int s = 0; s < int'(STEP); s++) begin
      trial = {rem_d, num_d[PadW-1]};
      num_d = {num_d[PadW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        num_d[0] = 1'b1;
      end
      rem_d = trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= PadW'(dividend_i);
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = num_q[DIVIDEND_W-1:0];
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

@@ rtl/label_flood_6_neighbor_unit.sv @@
// top level of the 6-neighbor label flood unit: label memory, sequencer, output register
// depends on lf6n_pkg, lf6n_div and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

// A write word never leaves idle. A read word passes S_RD_RESP to the output register.
// A flood word that floods runs on to S_EMIT; one that is dropped (outside the volume,
// or frontier voxel background or unlabeled) returns to idle from S_CHECK. Each result
// that finds the output register still full waits until it is free. Flood length is
// set by the two coordinate dividers (3 quotient bits per cycle over the 21-bit
// position) and by the single read port of the label memory, which fetches the six
// neighbors one per cycle before any of them is written back. The next word is taken
// only once the sequencer is back in idle, but a finished result may still wait in the
// output register. The label memory holds 2^21 entries, has no clearing pass and is
// undefined until written; the flood counter resets to zero and saturates.

`include "assert_macros.svh"

module label_flood_6_neighbor_unit #(
  parameter int unsigned MAX_SIDE   = lf6n_pkg::DEFAULT_MAX_SIDE,
  parameter int unsigned LABEL_BITS = lf6n_pkg::DEFAULT_LABEL_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // tdata: voxel_position[20:0], write_label[52:21], zero fill above
  input  wire logic [lf6n_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: func[1:0]
  input  wire logic [lf6n_pkg::FUNC_W-1:0]      s_axis_tuser,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: out_position[20:0], out_label[52:21], flooded_total[74:53], zero fill above
  output logic [lf6n_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // tuser: kind[0]
  output logic [0:0]                            m_axis_tuser,
  output logic                                  m_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  input  wire logic                             cfg_we_i,
  input  wire logic [lf6n_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [lf6n_pkg::DIM_W-1:0]       cfg_wdata_i
);

  localparam int unsigned PosW   = lf6n_pkg::POS_W;
  localparam int unsigned DimW   = lf6n_pkg::DIM_W;
  localparam int unsigned CntW   = lf6n_pkg::CNT_W;
  localparam int unsigned WLblW  = lf6n_pkg::WLABEL_W;
  localparam int unsigned NbNum  = 6;
  localparam int unsigned NbW    = $clog2(NbNum + 1);
  localparam int unsigned OutPad = lf6n_pkg::OUT_DATA_W - PosW - WLblW - CntW;

  localparam logic [LABEL_BITS-1:0] BgCode    = {LABEL_BITS{1'b1}};
  localparam logic [LABEL_BITS-1:0] UnlabCode = BgCode - 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_RESP,
    S_LAB,
    S_MUL,
    S_DIV,
    S_CHECK,
    S_COORD,
    S_NRD,
    S_EMIT
  } state_e;

  // configuration
  logic [DimW-1:0] dim_x_q, dim_y_q, dim_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= lf6n_pkg::DIM_RESET;
      dim_y_q <= lf6n_pkg::DIM_RESET;
      dim_z_q <= lf6n_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lf6n_pkg::CFG_DIM_X: dim_x_q <= cfg_wdata_i;
        lf6n_pkg::CFG_DIM_Y: dim_y_q <= cfg_wdata_i;
        lf6n_pkg::CFG_DIM_Z: dim_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input word
  logic                    s_acc;
  lf6n_pkg::func_e         in_func;
  logic [PosW-1:0]         in_pos;
  logic [WLblW-1:0]        in_label;

  assign in_func  = lf6n_pkg::func_e'(s_axis_tuser);
  assign in_pos   = s_axis_tdata[PosW-1:0];
  assign in_label = s_axis_tdata[PosW+WLblW-1:PosW];

  // sequencer and datapath registers
  state_e                 state_q;
  logic [PosW-1:0]        pos_q;
  logic [LABEL_BITS-1:0]  lab_q;
  logic [DimW-1:0]        ex_q, ey_q, ez_q;
  logic [2*DimW-1:0]      dxy_q;
  logic [3*DimW-1:0]      total_q;
  logic [DimW-1:0]        x_q, y_q, z_q;
  logic [NbNum-1:0]       inside_q;
  logic [NbNum-1:0]       hit_q;
  logic [PosW-1:0]        npos_q [NbNum];
  logic [NbW-1:0]         nb_q;
  logic [CntW-1:0]        cnt_q;

  logic                   out_valid_q;
  logic                   out_kind_q;
  logic                   out_last_q;
  logic [PosW-1:0]        out_pos_q;
  logic [WLblW-1:0]       out_label_q;
  logic [CntW-1:0]        out_total_q;

  // label memory
  logic [LABEL_BITS-1:0]  label_mem [lf6n_pkg::STORE_DEPTH];
  logic                   mem_we, mem_re;
  logic [PosW-1:0]        mem_waddr, mem_raddr;
  logic [LABEL_BITS-1:0]  mem_wdata;
  logic [LABEL_BITS-1:0]  mem_rdata_q;

  // dividers: x = pos mod dx, pos div dx, z = pos div dxy
  logic                   div_start;
  logic                   div_x_done, div_xy_done;
  logic [PosW-1:0]        quo_x, quo_xy;
  logic [DimW-1:0]        rem_x;

  // derived control
  logic                   slot_free;
  logic [PosW-1:0]        nb_pos;
  logic [NbNum-1:0]       hits;
  logic [NbNum-1:0]       later;
  logic                   cur_hit;
  logic                   emit_fire, emit_adv, emit_last;
  logic                   rd_load;
  logic                   out_load;
  logic                   drop;
  logic [2*DimW-1:0]      zdy, y_full;
  logic [CntW-1:0]        cnt_inc;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign div_start     = (state_q == S_MUL);

  always_comb begin
    nb_pos = '0;
    for (int i = 0; i < int'(NbNum); i++) begin
      if (nb_q == NbW'(i)) begin
        nb_pos = npos_q[i];
      end
    end
  end

  assign hits      = hit_q & inside_q;
  assign cur_hit   = hits[nb_q];
  assign later     = hits >> nb_q;
  assign emit_last = (later[NbNum-1:1] == '0);
  assign emit_fire = (state_q == S_EMIT) && cur_hit && slot_free;
  assign emit_adv  = (state_q == S_EMIT) && (!cur_hit || slot_free);
  assign rd_load   = (state_q == S_RD_RESP) && slot_free;
  assign out_load  = rd_load || emit_fire;
  assign cnt_inc   = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

  assign drop   = ({3'b0, pos_q} >= total_q) || (lab_q == BgCode) || (lab_q == UnlabCode);
  assign zdy    = quo_xy[DimW-1:0] * ey_q;
  assign y_full = quo_x[2*DimW-1:0] - zdy;

  always_comb begin
    mem_we    = emit_fire || (s_acc && (in_func == lf6n_pkg::FUNC_WRITE));
    mem_waddr = (state_q == S_EMIT) ? nb_pos : in_pos;
    mem_wdata = (state_q == S_EMIT) ? lab_q : in_label[LABEL_BITS-1:0];
    mem_re    = (s_acc && ((in_func == lf6n_pkg::FUNC_READ) ||
                           (in_func == lf6n_pkg::FUNC_FLOOD))) ||
                ((state_q == S_NRD) && (nb_q != NbW'(NbNum)));
    mem_raddr = (state_q == S_NRD) ? nb_pos : in_pos;
  end

  // read data only moves on a read, so a read answer can wait for the output slot
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      label_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= label_mem[mem_raddr];
    end
  end

  lf6n_div #(
    .DIVIDEND_W (PosW),
    .DIVISOR_W  (DimW),
    .STEP       (lf6n_pkg::DIV_STEP)
  ) u_div_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (pos_q),
    .divisor_i   (ex_q),
    .done_o      (div_x_done),
    .quotient_o  (quo_x),
    .remainder_o (rem_x)
  );

  lf6n_div #(
    .DIVIDEND_W (PosW),
    .DIVISOR_W  (2 * DimW),
    .STEP       (lf6n_pkg::DIV_STEP)
  ) u_div_xy (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (pos_q),
    .divisor_i   (dxy_q),
    .done_o      (div_xy_done),
    .quotient_o  (quo_xy),
    .remainder_o ()
  );

  // sequencer, counter and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nb_q        <= '0;
      hit_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= 1'b0;
      out_last_q  <= 1'b0;
      out_pos_q   <= '0;
      out_label_q <= '0;
      out_total_q <= '0;
    end else begin
      if (out_valid_q && m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            case (in_func)
              lf6n_pkg::FUNC_WRITE: ;
              lf6n_pkg::FUNC_READ:  state_q <= S_RD_RESP;
              lf6n_pkg::FUNC_FLOOD: state_q <= S_LAB;
              default: ;
            endcase
          end
        end
        S_RD_RESP: begin
          if (rd_load) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= 1'b0;
            out_last_q  <= 1'b1;
            out_pos_q   <= pos_q;
            out_label_q <= WLblW'(mem_rdata_q);
            out_total_q <= cnt_q;
            state_q     <= S_IDLE;
          end
        end
        S_LAB:   state_q <= S_MUL;
        S_MUL:   state_q <= S_DIV;
        S_DIV: begin
          if (div_x_done && div_xy_done) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: state_q <= drop ? S_IDLE : S_COORD;
        S_COORD: begin
          nb_q    <= '0;
          state_q <= S_NRD;
        end
        S_NRD: begin
          // read data arrives in the cycle after its address; shift it in from the top
          if (nb_q != '0) begin
            hit_q <= {(mem_rdata_q == UnlabCode), hit_q[NbNum-1:1]};
          end
          if (nb_q == NbW'(NbNum)) begin
            nb_q    <= '0;
            state_q <= S_EMIT;
          end else begin
            nb_q <= nb_q + 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            cnt_q       <= cnt_inc;
            out_valid_q <= 1'b1;
            out_kind_q  <= 1'b1;
            out_last_q  <= emit_last;
            out_pos_q   <= nb_pos;
            out_label_q <= WLblW'(lab_q);
            out_total_q <= cnt_inc;
          end
          if (emit_adv) begin
            if (nb_q == NbW'(NbNum - 1)) begin
              nb_q    <= '0;
              state_q <= S_IDLE;
            end else begin
              nb_q <= nb_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          pos_q <= in_pos;
          ex_q  <= lf6n_pkg::eff_dim(dim_x_q, MAX_SIDE);
          ey_q  <= lf6n_pkg::eff_dim(dim_y_q, MAX_SIDE);
          ez_q  <= lf6n_pkg::eff_dim(dim_z_q, MAX_SIDE);
        end
      end
      S_LAB: begin
        lab_q <= mem_rdata_q;
        dxy_q <= ex_q * ey_q;
      end
      S_MUL: total_q <= dxy_q * ez_q;
      S_CHECK: begin
        x_q <= rem_x;
        z_q <= quo_xy[DimW-1:0];
        y_q <= y_full[DimW-1:0];
      end
      S_COORD: begin
        // neighbor order: +z, +x, -x, +y, -y, -z
        inside_q[0] <= ((DimW+1)'(z_q) + 1'b1) < (DimW+1)'(ez_q);
        inside_q[1] <= ((DimW+1)'(x_q) + 1'b1) < (DimW+1)'(ex_q);
        inside_q[2] <= (x_q != '0);
        inside_q[3] <= ((DimW+1)'(y_q) + 1'b1) < (DimW+1)'(ey_q);
        inside_q[4] <= (y_q != '0);
        inside_q[5] <= (z_q != '0);
        npos_q[0]   <= pos_q + PosW'(dxy_q);
        npos_q[1]   <= pos_q + 1'b1;
        npos_q[2]   <= pos_q - 1'b1;
        npos_q[3]   <= pos_q + PosW'(ex_q);
        npos_q[4]   <= pos_q - PosW'(ex_q);
        npos_q[5]   <= pos_q - PosW'(dxy_q);
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {{OutPad{1'b0}}, out_total_q, out_label_q, out_pos_q};

  `ASSERT_IMPL(a_div_lockstep, div_x_done || div_xy_done, div_x_done && div_xy_done,
               "coordinate dividers out of step")
  `ASSERT_IMPL(a_coord_in_volume, state_q == S_COORD,
               (x_q < ex_q) && (y_q < ey_q) && (z_q < ez_q),
               "split coordinates outside the volume")
  `ASSERT_IMPL(a_emit_index, state_q == S_EMIT, nb_q < NbW'(NbNum),
               "neighbor index past the last neighbor")
  `ASSERT_NEXT(a_cnt_hold, !emit_fire, cnt_q == $past(cnt_q),
               "flood counter moved without a flooded voxel")

endmodule

`default_nettype wire

@@ tb/label_flood_6_neighbor_unit_tb.sv @@
// self-checking testbench of label_flood_6_neighbor_unit: label volume tracker class plus stream drivers
// depends on lf6n_pkg and the rtl of label_flood_6_neighbor_unit
`timescale 1ns / 1ps

localparam logic [31:0] BG_LABEL    = 32'hffff_ffff;
localparam logic [31:0] UNLAB_LABEL = 32'hffff_fffe;
localparam logic [21:0] COUNT_MAX   = 22'h3f_ffff;
localparam logic [1:0]  FUNC_SPARE  = 2'd3;

typedef struct packed {
  logic        kind;
  logic [20:0] pos;
  logic [31:0] label;
  logic [21:0] total;
  logic        last;
} answer_t;

// shadow of the label volume, flood counter and extents; predicts and checks output words
class label_volume_tracker;
  logic [31:0]  labels [int unsigned];
  int unsigned  written_pos [$];
  int unsigned  fresh_frontier [$];
  answer_t      due_answers [$];
  logic [21:0]  flooded_count;
  logic [7:0]   dim_reg [3];
  int unsigned  errors;

  function new();
    flooded_count = '0;
    dim_reg       = '{lf6n_pkg::DIM_RESET, lf6n_pkg::DIM_RESET, lf6n_pkg::DIM_RESET};
    errors        = 0;
  endfunction

  function void set_dim(logic [1:0] idx, logic [7:0] val);
    if (idx <= lf6n_pkg::CFG_DIM_Z) dim_reg[idx] = val;
  endfunction

  function int unsigned side(int k);
    if (dim_reg[k] == 0) return 1;
    if (dim_reg[k] > lf6n_pkg::DEFAULT_MAX_SIDE) return lf6n_pkg::DEFAULT_MAX_SIDE;
    return dim_reg[k];
  endfunction

  function int unsigned volume();
    return side(lf6n_pkg::CFG_DIM_X) * side(lf6n_pkg::CFG_DIM_Y) * side(lf6n_pkg::CFG_DIM_Z);
  endfunction

  function bit in_volume(int unsigned pos);
    return pos < volume();
  endfunction

  function bit written(int unsigned pos);
    return labels.exists(pos);
  endfunction

  // in-volume neighbors in visiting order +z, +x, -x, +y, -y, -z
  function int neighbor_list(int unsigned pos, output int unsigned nb [6]);
    int unsigned dx, dy, dz, x, y, z, rest;
    int cnt;
    dx   = side(lf6n_pkg::CFG_DIM_X);
    dy   = side(lf6n_pkg::CFG_DIM_Y);
    dz   = side(lf6n_pkg::CFG_DIM_Z);
    x    = pos % dx;
    rest = pos / dx;
    y    = rest % dy;
    z    = rest / dy;
    cnt  = 0;
    nb   = '{default: 0};
    if (z + 1 < dz) begin nb[cnt] = pos + dx * dy; cnt++; end
    if (x + 1 < dx) begin nb[cnt] = pos + 1;       cnt++; end
    if (x > 0)      begin nb[cnt] = pos - 1;       cnt++; end
    if (y + 1 < dy) begin nb[cnt] = pos + dx;      cnt++; end
    if (y > 0)      begin nb[cnt] = pos - dx;      cnt++; end
    if (z > 0)      begin nb[cnt] = pos - dx * dy; cnt++; end
    return cnt;
  endfunction

  function void note_word(logic [1:0] func, logic [20:0] pos, logic [31:0] wlabel);
    answer_t     held;
    bit          have_held;
    int unsigned nb [6];
    int          cnt;
    logic [31:0] lab;
    have_held = 1'b0;
    held      = '0;
    case (func)
      lf6n_pkg::FUNC_WRITE: begin
        if (!labels.exists(pos)) written_pos.push_back(pos);
        labels[pos] = wlabel;
      end
      lf6n_pkg::FUNC_READ: begin
        due_answers.push_back('{kind: 1'b0, pos: pos, label: labels[pos],
                                total: flooded_count, last: 1'b1});
      end
      lf6n_pkg::FUNC_FLOOD: begin
        if (in_volume(pos)) begin
          lab = labels[pos];
          if (lab != BG_LABEL && lab != UNLAB_LABEL) begin
            cnt = neighbor_list(pos, nb);
            for (int i = 0; i < cnt; i++) begin
              if (labels[nb[i]] == UNLAB_LABEL) begin
                labels[nb[i]] = lab;
                if (flooded_count != COUNT_MAX) flooded_count++;
                if (have_held) due_answers.push_back(held);
                held      = '{kind: 1'b1, pos: 21'(nb[i]), label: lab,
                              total: flooded_count, last: 1'b0};
                have_held = 1'b1;
                fresh_frontier.push_back(nb[i]);
              end
            end
            // only the final flooded neighbor carries last
            if (have_held) begin
              held.last = 1'b1;
              due_answers.push_back(held);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  function void check_word(answer_t got);
    answer_t want;
    if (due_answers.size() == 0) begin
      errors++;
      $display("%0t: word expected none got kind %0d pos %0h label %0h total %0h last %0d",
               $time, got.kind, got.pos, got.label, got.total, got.last);
      return;
    end
    want = due_answers.pop_front();
    compare_field("kind", 32'(want.kind), 32'(got.kind));
    compare_field("out_position", 32'(want.pos), 32'(got.pos));
    compare_field("out_label", want.label, got.label);
    compare_field("flooded_total", 32'(want.total), 32'(got.total));
    compare_field("last", 32'(want.last), 32'(got.last));
  endfunction
endclass

module label_flood_6_neighbor_unit_tb;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD     = 300;

  logic                                clk_i  = 1'b0;
  logic                                rst_ni = 1'b0;
  // tdata: voxel_position, write_label, zero fill
  logic [lf6n_pkg::IN_DATA_W-1:0]      s_axis_tdata  = '0;
  // tuser: func
  logic [lf6n_pkg::FUNC_W-1:0]         s_axis_tuser  = '0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  // tdata: out_position, out_label, flooded_total, zero fill
  logic [lf6n_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
  // tuser: kind
  logic [0:0]                          m_axis_tuser;
  logic                                m_axis_tlast;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic                                cfg_we_i      = 1'b0;
  logic [lf6n_pkg::CFG_IDX_W-1:0]      cfg_index_i   = '0;
  logic [lf6n_pkg::DIM_W-1:0]          cfg_wdata_i   = '0;

  label_volume_tracker sb = new();
  bit sender_gaps  = 1'b1;
  bit sink_gaps    = 1'b1;
  bit hold_request = 1'b0;

  label_flood_6_neighbor_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tdata,
    .s_axis_tuser,
    .s_axis_tvalid,
    .s_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] pick_label();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return UNLAB_LABEL;
    if (r < 70) return BG_LABEL;
    if (r < 80) return 32'($urandom_range(0, 15));
    return $urandom;
  endfunction

  task automatic send_word(input logic [1:0] func, input logic [20:0] pos,
                           input logic [31:0] wlabel);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tdata  <= {3'b000, wlabel, pos};
    s_axis_tuser  <= func;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(func, pos, wlabel);
  endtask

  // the block reads the frontier voxel and its neighbors, so any in-volume one not yet written gets written first
  task automatic flood_at(input int unsigned pos);
    int unsigned nb [6];
    int          cnt;
    if (sb.in_volume(pos)) begin
      if (!sb.written(pos)) send_word(lf6n_pkg::FUNC_WRITE, 21'(pos), $urandom);
      cnt = sb.neighbor_list(pos, nb);
      for (int i = 0; i < cnt; i++) begin
        if (!sb.written(nb[i])) send_word(lf6n_pkg::FUNC_WRITE, 21'(nb[i]), pick_label());
      end
    end
    send_word(lf6n_pkg::FUNC_FLOOD, 21'(pos), $urandom);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.due_answers.size() != 0) @(posedge clk_i);
    // a dropped flood may still be busy
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_dims(input logic [7:0] dx, input logic [7:0] dy, input logic [7:0] dz);
    logic [7:0] vals [3];
    logic [1:0] idxs [3];
    vals = '{dx, dy, dz};
    idxs = '{lf6n_pkg::CFG_DIM_X, lf6n_pkg::CFG_DIM_Y, lf6n_pkg::CFG_DIM_Z};
    drain_results();
    for (int k = 0; k < 3; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idxs[k];
      cfg_wdata_i <= vals[k];
      @(posedge clk_i);
      sb.set_dim(idxs[k], vals[k]);
    end
    cfg_we_i <= 1'b0;
    sb.fresh_frontier.delete();
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned span, pos, k, r;
    span = sb.volume();
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 45 && sb.fresh_frontier.size() != 0) begin
        k   = $urandom_range(0, sb.fresh_frontier.size() - 1);
        pos = sb.fresh_frontier[k];
        sb.fresh_frontier.delete(k);
        flood_at(pos);
      end else if (r < 60) begin
        flood_at($urandom_range(0, span - 1));
      end else if (r < 65) begin
        if (span < lf6n_pkg::STORE_DEPTH) flood_at($urandom_range(span, lf6n_pkg::STORE_DEPTH - 1));
        else flood_at($urandom_range(0, span - 1));
      end else if (r < 77) begin
        send_word(lf6n_pkg::FUNC_WRITE, 21'($urandom_range(0, lf6n_pkg::STORE_DEPTH - 1)),
                  pick_label());
      end else if (r < 90) begin
        k = $urandom_range(0, sb.written_pos.size() - 1);
        send_word(lf6n_pkg::FUNC_READ, 21'(sb.written_pos[k]), $urandom);
      end else if (r < 93) begin
        send_word(FUNC_SPARE, 21'($urandom), $urandom);
      end else begin
        // re-arm a voxel so later floods can take it
        send_word(lf6n_pkg::FUNC_WRITE, 21'($urandom_range(0, span - 1)), UNLAB_LABEL);
      end
    end
  endtask

  // sink stops for a long stretch while reads keep coming, so the input stalls
  task automatic squeeze_output();
    int unsigned k;
    hold_request = 1'b1;
    repeat (10) begin
      k = $urandom_range(0, sb.written_pos.size() - 1);
      send_word(lf6n_pkg::FUNC_READ, 21'(sb.written_pos[k]), $urandom);
    end
    drain_results();
  endtask

  initial begin : sink
    answer_t     got;
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind  = m_axis_tuser[0];
        got.pos   = m_axis_tdata[20:0];
        got.label = m_axis_tdata[52:21];
        got.total = m_axis_tdata[74:53];
        got.last  = m_axis_tlast;
        sb.check_word(got);
      end
      if (hold_request) begin
        stall_left   = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("label_flood_6_neighbor_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned waited;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset extents 128 cubed: corners, special frontier labels, spare func code
    send_word(lf6n_pkg::FUNC_WRITE, 21'd0, 32'd5);
    send_word(lf6n_pkg::FUNC_WRITE, 21'd1, UNLAB_LABEL);
    send_word(lf6n_pkg::FUNC_WRITE, 21'd128, BG_LABEL);
    send_word(lf6n_pkg::FUNC_WRITE, 21'd16384, UNLAB_LABEL);
    flood_at(0);
    send_word(lf6n_pkg::FUNC_READ, 21'd16384, 32'd0);
    send_word(lf6n_pkg::FUNC_WRITE, 21'h1f_ffff, 32'h0);
    flood_at(21'h1f_ffff);
    send_word(lf6n_pkg::FUNC_READ, 21'h1f_ffff, 32'hffff_ffff);
    flood_at(128);
    send_word(lf6n_pkg::FUNC_WRITE, 21'd200, UNLAB_LABEL);
    flood_at(200);
    send_word(FUNC_SPARE, 21'h1f_ffff, 32'hffff_ffff);

    // zero extents count as one: single voxel volume, raw addressing beyond it
    apply_dims(8'd0, 8'd0, 8'd0);
    send_word(lf6n_pkg::FUNC_WRITE, 21'd0, 32'h1234);
    flood_at(0);
    flood_at(1);
    flood_at(21'h1f_ffff);
    send_word(lf6n_pkg::FUNC_WRITE, 21'h10_0000, 32'h8000_0001);
    send_word(lf6n_pkg::FUNC_READ, 21'h10_0000, 32'd0);

    apply_dims(8'd3, 8'd3, 8'd3);
    random_phase(30);
    squeeze_output();
    apply_dims(8'd128, 8'd1, 8'd1);
    random_phase(25);
    apply_dims(8'd1, 8'd255, 8'd2);
    random_phase(25);
    apply_dims(8'd0, 8'd6, 8'd129);
    random_phase(25);
    repeat (2) begin
      apply_dims(8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)));
      random_phase(20);
    end

    sender_gaps = 1'b0;
    sink_gaps   = 1'b0;
    apply_dims(8'd4, 8'd4, 8'd4);
    random_phase(25);

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (sb.due_answers.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);
    if (sb.due_answers.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d words missing, next expected pos %0h label %0h got none", $time,
               sb.due_answers.size(), sb.due_answers[0].pos, sb.due_answers[0].label);
    end
    if (sb.errors == 0) begin
      $display("label_flood_6_neighbor_unit verification clean");
    end else begin
      $display("label_flood_6_neighbor_unit verification failed");
    end
    $finish;
  end

endmodule
